/* design/sle_pkg.sv */
// Shared types, codes and sizes for the sorted list engine.
package sle_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [VALUE_W-1:0] value;
  } sle_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] position;
    logic       found;
    logic [4:0] count;
  } sle_out_t;

endpackage

/* design/sle_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module sle_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/sorted_list_engine.sv */
// Sorted list engine: ascending list of signed values held in one RAM, with a sequencer.
// Sequence: the lower-bound scan reads one entry per cycle and stops at the first entry not
// less than the value (at most count reads), then the sequencer decides, moves entries one
// by one, writes an inserted value and loads the result.
// Throughput: one request at a time, accepted in the cycle after its result is loaded; a stalled
// result holds the sequencer. Reset clears the count and control state, not the entry RAM.
module sorted_list_engine
  import sle_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sle_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sle_out_t out_data_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_SHUP = 3'd3;
  localparam logic [2:0] S_SHDN = 3'd4;
  localparam logic [2:0] S_INS  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]                state_q, state_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [CNT_W-1:0]          idx_q, idx_d;
  logic [CNT_W-1:0]          pos_q, pos_d;
  logic [IDX_W-1:0]          j_q, j_d;
  logic                      hit_q, hit_d;
  logic [1:0]                op_q, op_d;
  logic signed [VALUE_W-1:0] v_q, v_d;
  logic [1:0]                status_q, status_d;
  logic                      out_valid_q, out_valid_d;
  sle_out_t                  out_q, out_d;

  logic                      in_acc;
  logic                      out_load;
  logic [CNT_W-1:0]          idx_inc;
  logic                      ram_we, ram_re;
  logic [IDX_W-1:0]          ram_waddr, ram_raddr;
  logic [VALUE_W-1:0]        ram_wdata, ram_rdata;

  sle_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign idx_inc    = idx_q + CNT_W'(1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    j_d       = j_q;
    hit_d     = hit_q;
    op_d      = op_q;
    v_d       = v_q;
    status_d  = status_q;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = j_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d  = in_data_i.op;
          v_d   = in_data_i.value;
          pos_d = '0;
          hit_d = 1'b0;
          idx_d = '0;
          if (count_q == '0) begin
            state_d = S_ACT;
          end else begin
            ram_re  = 1'b1;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // The read data belongs to entry idx_q.
        if ($signed(ram_rdata) < v_q) begin
          if (idx_inc == count_q) begin
            pos_d   = count_q;
            state_d = S_ACT;
          end else begin
            idx_d     = idx_inc;
            ram_re    = 1'b1;
            ram_raddr = IDX_W'(idx_inc);
          end
        end else begin
          pos_d   = idx_q;
          hit_d   = (ram_rdata == v_q);
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        priority if (op_q == OP_INSERT) begin
          if (count_q == CNT_W'(DEPTH)) begin
            status_d = ST_FULL;
            state_d  = S_FIN;
          end else if (pos_q == count_q) begin
            state_d = S_INS;
          end else begin
            j_d       = IDX_W'(count_q);
            ram_re    = 1'b1;
            ram_raddr = IDX_W'(count_q - CNT_W'(1));
            state_d   = S_SHUP;
          end
        end else if (count_q == '0) begin
          status_d = ST_EMPTY;
          state_d  = S_FIN;
        end else if (op_q == OP_REMOVE) begin
          if (!hit_q) begin
            status_d = ST_NOTFOUND;
            state_d  = S_FIN;
          end else if (pos_q + CNT_W'(1) == count_q) begin
            count_d  = count_q - CNT_W'(1);
            status_d = ST_OK;
            state_d  = S_FIN;
          end else begin
            j_d       = IDX_W'(pos_q);
            ram_re    = 1'b1;
            ram_raddr = IDX_W'(pos_q + CNT_W'(1));
            state_d   = S_SHDN;
          end
        end else begin
          // Lookup, and the unused op code, which behaves as a lookup.
          status_d = hit_q ? ST_OK : ST_NOTFOUND;
          state_d  = S_FIN;
        end
      end
      S_SHUP: begin
        // Move entry j-1 up to j while the read of entry j-2 is under way.
        ram_we = 1'b1;
        if (CNT_W'(j_q) == pos_q + CNT_W'(1)) begin
          state_d = S_INS;
        end else begin
          j_d       = j_q - IDX_W'(1);
          ram_re    = 1'b1;
          ram_raddr = j_q - IDX_W'(2);
        end
      end
      S_SHDN: begin
        ram_we = 1'b1;
        if (CNT_W'(j_q) + CNT_W'(2) == count_q) begin
          count_d  = count_q - CNT_W'(1);
          status_d = ST_OK;
          state_d  = S_FIN;
        end else begin
          j_d       = j_q + IDX_W'(1);
          ram_re    = 1'b1;
          ram_raddr = j_q + IDX_W'(2);
        end
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(pos_q);
        ram_wdata = v_q;
        count_d   = count_q + CNT_W'(1);
        status_d  = ST_OK;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d          = out_q;
    out_d.status   = status_q;
    out_d.position = 5'(pos_q);
    out_d.found    = hit_q;
    out_d.count    = 5'(count_q);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    j_q      <= j_d;
    hit_q    <= hit_d;
    op_q     <= op_d;
    v_q      <= v_d;
    status_q <= status_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A shift step never reads the entry it writes in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("RAM read and write hit the same entry");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above list depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |->
      (count_q == $past(count_q) + CNT_W'(1)) || (count_q == $past(count_q) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_FULL) |-> out_data_o.count == 5'(DEPTH))
    else $error("full status reported on a list that is not full");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> $stable(count_q))
    else $error("entry count changed without a request in progress");

endmodule
